[design/tqb_pkg.sv]
`timescale 1ns / 1ps
package tqb_pkg;

    localparam int TexMaxDim    = 64;
    localparam int ScreenMaxDim = 4096;
    localparam int StoreDepth   = TexMaxDim * TexMaxDim;
    localparam int AddrW        = $clog2(StoreDepth);
    localparam int TexDimW      = 7;
    localparam int QW           = $clog2(TexMaxDim);
    localparam int ScrW         = 13;
    localparam int CoordW       = 12;
    localparam int ScaleW       = 12;
    localparam int WdW          = ScaleW + TexDimW;
    localparam int PosW         = CoordW + 10;
    localparam int NumW         = WdW + 1 + QW;
    localparam int ChanW        = 8;
    localparam int BlW          = 26;
    localparam int BlendDiv     = 130050;
    localparam int BlendBias    = 65025;
    localparam int BlendRecip   = 33818121;
    localparam int BlendShift   = 42;
    localparam int RcpW         = 26;
    localparam int PrW          = BlW + RcpW;
    localparam int CfgIdxW      = 3;
    localparam int CfgDataW     = 24;
    localparam int InDataW      = 104;
    localparam int FifoDepth    = 4;
    localparam int FifoPtrW     = $clog2(FifoDepth);

    localparam logic FuncLoad = 1'b0;

    typedef enum logic [CfgIdxW-1:0] {
        REG_ORIGIN_X      = 3'd0,
        REG_ORIGIN_Y      = 3'd1,
        REG_SCALE_FACTOR  = 3'd2,
        REG_TINT_RGB      = 3'd3,
        REG_TEX_WIDTH     = 3'd4,
        REG_TEX_HEIGHT    = 3'd5,
        REG_SCREEN_WIDTH  = 3'd6,
        REG_SCREEN_HEIGHT = 3'd7
    } cfg_reg_t;

    typedef enum logic [1:0] {
        CLS_LOAD,
        CLS_SKIP,
        CLS_DRAW
    } item_cls_t;

    typedef struct packed {
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
        logic [TexDimW-1:0] tw;
        logic [TexDimW-1:0] th;
        logic [QW-1:0]      twm1;
        logic [QW-1:0]      thm1;
        logic [WdW-1:0]     wd;
        logic [WdW-1:0]     ht;
        logic [ScrW-1:0]    sw;
        logic [ScrW-1:0]    sh;
        logic [23:0]        tint;
    } cfg_t;

    typedef struct packed {
        item_cls_t      cls;
        logic [AddrW-1:0] addr;
        logic [31:0]    word;
        logic [WdW-1:0] dx;
        logic [WdW-1:0] dy;
    } item_t;

endpackage

[design/tqb_cfg.sv]
`timescale 1ns / 1ps
module tqb_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tqb_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [tqb_pkg::CfgDataW-1:0]  cfg_data,
    output tqb_pkg::cfg_t                 cfg
);

    logic signed [15:0]              origin_x_reg, origin_y_reg;
    logic [tqb_pkg::ScaleW-1:0]      scale_reg;
    logic [23:0]                     tint_reg;
    logic [tqb_pkg::TexDimW-1:0]     tex_w_reg, tex_h_reg;
    logic [tqb_pkg::ScrW-1:0]        scr_w_reg, scr_h_reg;
    tqb_pkg::cfg_t                   cfg_reg, cfg_next;

    function automatic tqb_pkg::cfg_t derive(
        input logic signed [15:0]          ox,
        input logic signed [15:0]          oy,
        input logic [tqb_pkg::ScaleW-1:0]  sc,
        input logic [23:0]                 tn,
        input logic [tqb_pkg::TexDimW-1:0] tw_raw,
        input logic [tqb_pkg::TexDimW-1:0] th_raw,
        input logic [tqb_pkg::ScrW-1:0]    sw_raw,
        input logic [tqb_pkg::ScrW-1:0]    sh_raw
    );
        tqb_pkg::cfg_t d;
        logic [tqb_pkg::TexDimW-1:0] tw, th;
        tw = (tw_raw > tqb_pkg::TexDimW'(tqb_pkg::TexMaxDim)) ?
             tqb_pkg::TexDimW'(tqb_pkg::TexMaxDim) : tw_raw;
        th = (th_raw > tqb_pkg::TexDimW'(tqb_pkg::TexMaxDim)) ?
             tqb_pkg::TexDimW'(tqb_pkg::TexMaxDim) : th_raw;
        d.origin_x = ox;
        d.origin_y = oy;
        d.tw       = tw;
        d.th       = th;
        d.twm1     = tqb_pkg::QW'(tw - 1'b1);
        d.thm1     = tqb_pkg::QW'(th - 1'b1);
        d.wd       = tqb_pkg::WdW'(sc) * tqb_pkg::WdW'(tw);
        d.ht       = tqb_pkg::WdW'(sc) * tqb_pkg::WdW'(th);
        d.sw       = (sw_raw > tqb_pkg::ScrW'(tqb_pkg::ScreenMaxDim)) ?
                     tqb_pkg::ScrW'(tqb_pkg::ScreenMaxDim) : sw_raw;
        d.sh       = (sh_raw > tqb_pkg::ScrW'(tqb_pkg::ScreenMaxDim)) ?
                     tqb_pkg::ScrW'(tqb_pkg::ScreenMaxDim) : sh_raw;
        d.tint     = tn;
        return d;
    endfunction

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = derive(origin_x_reg, origin_y_reg, scale_reg, tint_reg,
                          tex_w_reg, tex_h_reg, scr_w_reg, scr_h_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            scale_reg    <= tqb_pkg::ScaleW'(256);
            tint_reg     <= 24'hffffff;
            tex_w_reg    <= tqb_pkg::TexDimW'(64);
            tex_h_reg    <= tqb_pkg::TexDimW'(64);
            scr_w_reg    <= tqb_pkg::ScrW'(640);
            scr_h_reg    <= tqb_pkg::ScrW'(480);
            cfg_reg      <= derive(16'sd0, 16'sd0, tqb_pkg::ScaleW'(256), 24'hffffff,
                                   tqb_pkg::TexDimW'(64), tqb_pkg::TexDimW'(64),
                                   tqb_pkg::ScrW'(640), tqb_pkg::ScrW'(480));
        end else begin
            cfg_reg <= cfg_next;
            if (cfg_valid) begin
                unique case (tqb_pkg::cfg_reg_t'(cfg_index))
                    tqb_pkg::REG_ORIGIN_X:      origin_x_reg <= cfg_data[15:0];
                    tqb_pkg::REG_ORIGIN_Y:      origin_y_reg <= cfg_data[15:0];
                    tqb_pkg::REG_SCALE_FACTOR:  scale_reg <= cfg_data[tqb_pkg::ScaleW-1:0];
                    tqb_pkg::REG_TINT_RGB:      tint_reg <= cfg_data[23:0];
                    tqb_pkg::REG_TEX_WIDTH:     tex_w_reg <= cfg_data[tqb_pkg::TexDimW-1:0];
                    tqb_pkg::REG_TEX_HEIGHT:    tex_h_reg <= cfg_data[tqb_pkg::TexDimW-1:0];
                    tqb_pkg::REG_SCREEN_WIDTH:  scr_w_reg <= cfg_data[tqb_pkg::ScrW-1:0];
                    tqb_pkg::REG_SCREEN_HEIGHT: scr_h_reg <= cfg_data[tqb_pkg::ScrW-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

[design/tqb_front.sv]
`timescale 1ns / 1ps
module tqb_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tqb_pkg::InDataW-1:0]   s_tdata,
    input  logic                          s_tuser,
    input  tqb_pkg::cfg_t                 cfg,
    input  logic                          fifo_full,
    output logic                          push,
    output tqb_pkg::item_t                push_item
);

    logic                        in_vld_reg;
    logic                        in_func_reg;
    logic [tqb_pkg::InDataW-1:0] in_data_reg;

    logic [tqb_pkg::CoordW-1:0]      px, py;
    logic signed [tqb_pkg::PosW-1:0] dx, dy;
    logic                            in_rect;

    assign s_tready = !in_vld_reg || !fifo_full;
    assign push     = in_vld_reg && !fifo_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_func_reg <= s_tuser;
            in_data_reg <= s_tdata;
        end
    end

    always_comb begin
        px = in_data_reg[55:44];
        py = in_data_reg[67:56];
        dx = $signed({2'b00, px, 8'h00})
           - ($signed(tqb_pkg::PosW'(cfg.origin_x)) <<< 4);
        dy = $signed({2'b00, py, 8'h00})
           - ($signed(tqb_pkg::PosW'(cfg.origin_y)) <<< 4);
        in_rect = (dx > 0) && (dx < $signed(tqb_pkg::PosW'(cfg.wd)))
               && (dy > 0) && (dy < $signed(tqb_pkg::PosW'(cfg.ht)))
               && (tqb_pkg::ScrW'(px) < cfg.sw) && (tqb_pkg::ScrW'(py) < cfg.sh);

        push_item.addr = in_data_reg[11:0];
        push_item.dx   = dx[tqb_pkg::WdW-1:0];
        push_item.dy   = dy[tqb_pkg::WdW-1:0];
        if (in_func_reg == tqb_pkg::FuncLoad) begin
            push_item.cls  = tqb_pkg::CLS_LOAD;
            push_item.word = in_data_reg[43:12];
        end else begin
            push_item.cls  = in_rect ? tqb_pkg::CLS_DRAW : tqb_pkg::CLS_SKIP;
            push_item.word = in_data_reg[99:68];
        end
    end

endmodule

[design/tqb_fifo.sv]
`timescale 1ns / 1ps
module tqb_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  tqb_pkg::item_t  push_item,
    output logic            full,
    input  logic            pop,
    output logic            valid,
    output tqb_pkg::item_t  pop_item
);

    tqb_pkg::item_t                entry_reg [tqb_pkg::FifoDepth];
    logic [tqb_pkg::FifoPtrW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [tqb_pkg::FifoPtrW:0]    count_reg, count_next;

    assign full     = (count_reg == (tqb_pkg::FifoPtrW+1)'(tqb_pkg::FifoDepth));
    assign valid    = (count_reg != '0);
    assign pop_item = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[design/tqb_back.sv]
`timescale 1ns / 1ps
module tqb_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  tqb_pkg::cfg_t   cfg,
    input  logic            fifo_valid,
    input  tqb_pkg::item_t  fifo_item,
    output logic            pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [31:0]     m_tdata,
    output logic            m_tuser
);

    localparam int QW   = tqb_pkg::QW;
    localparam int NumW = tqb_pkg::NumW;
    localparam int BlW  = tqb_pkg::BlW;
    localparam int PrW  = tqb_pkg::PrW;
    localparam int CW   = tqb_pkg::ChanW;

    logic en;

    logic            a_vld_reg;
    tqb_pkg::item_t  a_item_reg;

    logic                dv_vld_reg  [QW+1];
    tqb_pkg::item_cls_t  dv_cls_reg  [QW+1];
    logic [tqb_pkg::AddrW-1:0] dv_addr_reg [QW+1];
    logic [31:0]         dv_word_reg [QW+1];
    logic [NumW-1:0]     dv_rx_reg   [QW+1];
    logic [NumW-1:0]     dv_ry_reg   [QW+1];
    logic [QW-1:0]       dv_qx_reg   [QW+1];
    logic [QW-1:0]       dv_qy_reg   [QW+1];

    logic                c_vld_reg;
    tqb_pkg::item_cls_t  c_cls_reg;
    logic [tqb_pkg::AddrW-1:0] c_addr_reg;
    logic [31:0]         c_word_reg;

    logic [31:0]         tex_mem [tqb_pkg::StoreDepth];
    logic [31:0]         tex_rd_reg;
    logic                mm_vld_reg;
    tqb_pkg::item_cls_t  mm_cls_reg;
    logic [23:0]         mm_dest_reg;

    logic                p1_vld_reg;
    tqb_pkg::item_cls_t  p1_cls_reg;
    logic [2:0][2*CW-1:0] p1_od_reg, p1_cg_reg;
    logic [CW-1:0]       p1_a_reg;

    logic                bl_vld_reg [2];
    tqb_pkg::item_cls_t  bl_cls_reg [2];
    logic [2:0][BlW-1:0] bl_num_reg;
    logic [2:0][PrW-1:0] bl_prod_reg;

    logic                out_vld_reg;
    logic [31:0]         out_data_reg;
    logic                out_user_reg;

    assign en       = !out_vld_reg || m_tready;
    assign pop      = en && fifo_valid;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
        end else if (en) begin
            a_vld_reg <= fifo_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_item_reg <= fifo_item;
        end
    end

    // numerators for the texel coordinate divides
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_vld_reg[0] <= 1'b0;
        end else if (en) begin
            dv_vld_reg[0] <= a_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dv_cls_reg[0]  <= a_item_reg.cls;
            dv_addr_reg[0] <= a_item_reg.addr;
            dv_word_reg[0] <= a_item_reg.word;
            dv_rx_reg[0]   <= ((NumW'(a_item_reg.dx) * NumW'(cfg.twm1)) << 1)
                            + NumW'(cfg.wd);
            dv_ry_reg[0]   <= NumW'(a_item_reg.dy) * NumW'(cfg.thm1);
            dv_qx_reg[0]   <= '0;
            dv_qy_reg[0]   <= '0;
        end
    end

    // one quotient bit per stage, high bit first
    for (genvar i = 0; i < QW; i++) begin : g_div
        localparam int K = QW - 1 - i;
        logic [NumW-1:0] trial_x, trial_y;
        assign trial_x = (NumW'(cfg.wd) << 1) << K;
        assign trial_y = NumW'(cfg.ht) << K;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_vld_reg[i+1] <= 1'b0;
            end else if (en) begin
                dv_vld_reg[i+1] <= dv_vld_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dv_cls_reg[i+1]  <= dv_cls_reg[i];
                dv_addr_reg[i+1] <= dv_addr_reg[i];
                dv_word_reg[i+1] <= dv_word_reg[i];
                if (dv_rx_reg[i] >= trial_x) begin
                    dv_rx_reg[i+1] <= dv_rx_reg[i] - trial_x;
                    dv_qx_reg[i+1] <= dv_qx_reg[i] | (QW'(1) << K);
                end else begin
                    dv_rx_reg[i+1] <= dv_rx_reg[i];
                    dv_qx_reg[i+1] <= dv_qx_reg[i];
                end
                if (dv_ry_reg[i] >= trial_y) begin
                    dv_ry_reg[i+1] <= dv_ry_reg[i] - trial_y;
                    dv_qy_reg[i+1] <= dv_qy_reg[i] | (QW'(1) << K);
                end else begin
                    dv_ry_reg[i+1] <= dv_ry_reg[i];
                    dv_qy_reg[i+1] <= dv_qy_reg[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_vld_reg <= 1'b0;
        end else if (en) begin
            c_vld_reg <= dv_vld_reg[QW];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_cls_reg  <= dv_cls_reg[QW];
            c_word_reg <= dv_word_reg[QW];
            if (dv_cls_reg[QW] == tqb_pkg::CLS_LOAD) begin
                c_addr_reg <= dv_addr_reg[QW];
            end else begin
                c_addr_reg <= tqb_pkg::AddrW'(dv_qy_reg[QW]) * tqb_pkg::AddrW'(cfg.tw)
                            + tqb_pkg::AddrW'(dv_qx_reg[QW]);
            end
        end
    end

    // loads write and shades read at the same stage, so order holds
    always_ff @(posedge aclk) begin
        if (en) begin
            if (c_vld_reg && c_cls_reg == tqb_pkg::CLS_LOAD
                && 32'(c_addr_reg) < 32'(tqb_pkg::StoreDepth)) begin
                tex_mem[c_addr_reg] <= c_word_reg;
            end
            tex_rd_reg <= tex_mem[c_addr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mm_vld_reg <= 1'b0;
        end else if (en) begin
            mm_vld_reg <= c_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mm_cls_reg  <= c_cls_reg;
            mm_dest_reg <= c_word_reg[31:8];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_vld_reg <= 1'b0;
        end else if (en) begin
            p1_vld_reg <= mm_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_cls_reg <= mm_cls_reg;
            p1_a_reg   <= tex_rd_reg[7:0];
            for (int c = 0; c < 3; c++) begin
                p1_od_reg[c] <= (2*CW)'(mm_dest_reg[c*CW +: CW])
                              * (2*CW)'(8'd255 - tex_rd_reg[7:0]);
                p1_cg_reg[c] <= (2*CW)'(tex_rd_reg[(c+1)*CW +: CW])
                              * (2*CW)'(cfg.tint[c*CW +: CW]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bl_vld_reg[0] <= 1'b0;
            bl_vld_reg[1] <= 1'b0;
        end else if (en) begin
            bl_vld_reg[0] <= p1_vld_reg;
            bl_vld_reg[1] <= bl_vld_reg[0];
        end
    end

    // divide by the blend constant through a reciprocal multiply
    always_ff @(posedge aclk) begin
        if (en) begin
            bl_cls_reg[0] <= p1_cls_reg;
            bl_cls_reg[1] <= bl_cls_reg[0];
            for (int c = 0; c < 3; c++) begin
                bl_num_reg[c]  <= ((((BlW'(p1_od_reg[c]) << 8) - BlW'(p1_od_reg[c]))
                                 + BlW'(p1_cg_reg[c]) * BlW'(p1_a_reg)) << 1)
                                + BlW'(tqb_pkg::BlendBias);
                bl_prod_reg[c] <= PrW'(bl_num_reg[c]) * PrW'(tqb_pkg::BlendRecip);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= bl_vld_reg[1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (bl_cls_reg[1] == tqb_pkg::CLS_DRAW) begin
                out_data_reg <= {bl_prod_reg[2][tqb_pkg::BlendShift +: CW],
                                 bl_prod_reg[1][tqb_pkg::BlendShift +: CW],
                                 bl_prod_reg[0][tqb_pkg::BlendShift +: CW], 8'hff};
                out_user_reg <= 1'b1;
            end else begin
                out_data_reg <= '0;
                out_user_reg <= 1'b0;
            end
        end
    end

endmodule

[design/textured_quad_blend_shader_core.sv]
`timescale 1ns / 1ps
// Throughput: one word per cycle; the back pipeline stalls as a whole on m_tready.
// Texel coordinates come from two 6-stage pipelined dividers, the blend from a
// reciprocal multiply by constant; the texture store has one write/read port.
// Reset: aresetn synchronous, active low; clears control and config registers.
// The texture store is not cleared; texels read as loaded.
module textured_quad_blend_shader_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tqb_pkg::InDataW-1:0]   s_tdata,   // texel_index, texel_word, pixel_x,
                                                     // pixel_y, dest_pixel, pad
    input  logic                          s_tuser,   // func
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [31:0]                   m_tdata,   // pixel_out
    output logic                          m_tuser,   // write_pixel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tqb_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [tqb_pkg::CfgDataW-1:0]  cfg_data
);

    tqb_pkg::cfg_t  cfg;
    tqb_pkg::item_t push_item, pop_item;
    logic           push, pop, fifo_full, fifo_valid;

    tqb_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tqb_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg       (cfg),
        .fifo_full (fifo_full),
        .push      (push),
        .push_item (push_item)
    );

    tqb_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (fifo_full),
        .pop       (pop),
        .valid     (fifo_valid),
        .pop_item  (pop_item)
    );

    tqb_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .fifo_valid (fifo_valid),
        .fifo_item  (pop_item),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

[design/tqb_checker.sv]
`timescale 1ns / 1ps
module tqb_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser
);

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_skip_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == 32'h0)
        else $error("unwritten pixel not zero");

    a_alpha_ff: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[7:0] == 8'hff)
        else $error("written pixel alpha not 0xff");

endmodule

bind textured_quad_blend_shader_core tqb_checker u_tqb_checker (.*);
